@@ rtl/core/lrqs_pkg.sv @@
// Shared types and constants of the lottery run-queue scheduler.
package lrqs_pkg;

	localparam int MaxProcs = 64;
	localparam int IdW      = 6;
	localparam int PosW     = 6;
	localparam int CntW     = 7;
	localparam int TktW     = 16;
	localparam int SumW     = 22;
	localparam int DrawW    = 31;
	localparam int SliceW   = 16;
	localparam int StatW    = 3;
	localparam int QW       = IdW + TktW;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PICK = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [StatW-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_DUP    = 3'd2,
		ST_ABSENT = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_SLICE,
		S_ENQ,
		S_DEQ_RD,
		S_DEQ_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_MOD,
		S_WALK_RD,
		S_WALK_CMP,
		S_OUT
	} state_t;

endpackage

@@ rtl/core/lrqs_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module lrqs_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/lottery_run_queue_scheduler.sv @@
// Top level of the lottery run-queue scheduler.
//
//  channel | direction | handshake           | content
//  --------+-----------+---------------------+--------------------------------------
//  in      | input     | in_valid/in_ready   | op, proc_id, priority_req, random_value
//  out     | output    | out_valid/out_ready | status, picked_*, resched, queued_count
//  cfg     | input     | cfg_we              | cfg_wdata -> slice limit register
//
// One item at a time. Enqueue and tick do a slice memory read-modify-write; a
// rejected enqueue or dequeue and a pick on an empty queue go straight to the
// result. Dequeue reads the entries ahead of the match, then shifts each entry
// behind it down by one (one queue access a cycle). Pick computes a bit-serial
// remainder over all draw bits, then walks the entries. After reset a clearing
// pass zeroes all 64 entries of the slice memory; no item is accepted
// meanwhile. A result waits in the output register while the sink stalls; the
// next item is taken the cycle after the result transfer.
module lottery_run_queue_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [lrqs_pkg::IdW-1:0]    proc_id,
	input  logic [lrqs_pkg::TktW-1:0]   priority_req,
	input  logic [lrqs_pkg::DrawW-1:0]  random_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lrqs_pkg::StatW-1:0]  status,
	output logic                        picked_valid,
	output logic [lrqs_pkg::IdW-1:0]    picked_proc,
	output logic                        resched,
	output logic [lrqs_pkg::CntW-1:0]   queued_count,
	input  logic                        cfg_we,
	input  logic [lrqs_pkg::SliceW-1:0] cfg_wdata
);
	import lrqs_pkg::*;

	state_t state_q, state_d;

	// Held copy of the accepted item.
	op_t               op_q;
	logic [IdW-1:0]    pid_q;
	logic [TktW-1:0]   tkt_q;
	logic [DrawW-1:0]  draw_q;

	logic [SliceW-1:0] max_slice_q;
	logic [CntW-1:0]   len_q;
	logic [SumW-1:0]   sum_q;
	logic [MaxProcs-1:0] queued_q;

	// Walk and divider state.
	logic [PosW-1:0]   pos_q;
	logic [SumW-1:0]   rem_q;
	logic [4:0]        bit_q;
	logic [IdW-1:0]    first_id_q;

	// Result register.
	logic [StatW-1:0]  status_q;
	logic              pvalid_q;
	logic [IdW-1:0]    pproc_q;
	logic              resched_q;

	// Queue memory: {id, tickets}.
	logic            q_we;
	logic [PosW-1:0] q_waddr, q_raddr;
	logic [QW-1:0]   q_wdata, q_rdata;
	logic [IdW-1:0]  rd_id;
	logic [TktW-1:0] rd_tkt;

	// Slice memory, indexed by process id.
	logic              s_we;
	logic [IdW-1:0]    s_waddr;
	logic [SliceW-1:0] s_wdata, s_rdata;

	lrqs_ram #(.Width(QW), .Depth(MaxProcs)) u_queue_ram (
		.clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
	);

	lrqs_ram #(.Width(SliceW), .Depth(MaxProcs)) u_slice_ram (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(pid_q), .rdata(s_rdata)
	);

	assign rd_id  = q_rdata[QW-1:TktW];
	assign rd_tkt = q_rdata[TktW-1:0];

	logic [TktW-1:0] new_tkt;
	assign new_tkt = (tkt_q == '0) ? TktW'(1) : tkt_q;

	// Restoring remainder: shift in one draw bit, subtract if it fits.
	logic [SumW:0] rem_sh;
	assign rem_sh = {rem_q, draw_q[bit_q]};

	logic last_pos;
	assign last_pos = ({1'b0, pos_q} + CntW'(1)) >= len_q;

	assign in_ready  = (state_q == S_IDLE) && !out_valid;
	assign status       = status_q;
	assign picked_valid = pvalid_q;
	assign picked_proc  = pproc_q;
	assign resched      = resched_q;
	assign queued_count = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_d = state_q;
		q_we    = 1'b0;
		q_waddr = pos_q;
		q_wdata = {rd_id, rd_tkt};
		q_raddr = pos_q;
		s_we    = 1'b0;
		s_waddr = pid_q;
		s_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				s_we    = 1'b1;
				s_waddr = pos_q;
				if (pos_q == PosW'(MaxProcs - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					unique case (op_t'(op))
						OP_ENQ, OP_TICK: state_d = S_SLICE;
						OP_DEQ:          state_d = S_DEQ_RD;
						OP_PICK:         state_d = S_MOD;
						default:         state_d = S_IDLE;
					endcase
				end
			end
			S_SLICE: begin
				state_d = S_ENQ;
				if (op_q == OP_ENQ && (queued_q[pid_q] || len_q >= CntW'(MaxProcs))) begin
					state_d = S_OUT;
				end
			end
			S_ENQ: begin
				// Slice read data is valid now.
				if (op_q == OP_ENQ) begin
					q_we    = 1'b1;
					q_waddr = len_q[PosW-1:0];
					q_wdata = {pid_q, new_tkt};
					s_we    = (s_rdata == '0) || (s_rdata > max_slice_q);
					s_wdata = max_slice_q;
				end else begin
					s_we    = 1'b1;
					s_wdata = (s_rdata != '0) ? s_rdata - SliceW'(1) : '0;
				end
				state_d = S_OUT;
			end
			S_DEQ_RD: begin
				state_d = queued_q[pid_q] ? S_DEQ_CMP : S_OUT;
			end
			S_DEQ_CMP: begin
				if (rd_id == pid_q) begin
					state_d = last_pos ? S_OUT : S_SHIFT_RD;
					q_raddr = pos_q + PosW'(1);
				end else begin
					state_d = last_pos ? S_OUT : S_DEQ_RD;
					q_raddr = pos_q + PosW'(1);
				end
			end
			S_SHIFT_RD: begin
				// Hold the read on entry pos+1.
				q_raddr = pos_q + PosW'(1);
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				// rd holds entry pos+1; move it down to pos. len_q is already shortened.
				q_we    = 1'b1;
				q_waddr = pos_q;
				state_d = ({1'b0, pos_q} + CntW'(2) > len_q) ? S_OUT : S_SHIFT_RD;
				q_raddr = pos_q + PosW'(2);
			end
			S_MOD: begin
				q_raddr = '0;
				if (len_q == '0) begin
					state_d = S_OUT;
				end else if (bit_q == '0) begin
					state_d = S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				state_d = S_WALK_CMP;
			end
			S_WALK_CMP: begin
				q_raddr = pos_q + PosW'(1);
				if (SumW'(rd_tkt) > rem_q || last_pos) begin
					state_d = S_OUT;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slice_q <= SliceW'(5);
			len_q       <= '0;
			sum_q       <= '0;
			queued_q    <= '0;
			out_valid   <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (cfg_we) begin
				max_slice_q <= cfg_wdata;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: pos_q <= pos_q + PosW'(1);
				S_IDLE: begin
					pos_q <= '0;
					if (in_valid && in_ready) begin
						op_q   <= op_t'(op);
						pid_q  <= proc_id;
						tkt_q  <= priority_req;
						draw_q <= random_value;
						status_q  <= ST_OK;
						pvalid_q  <= 1'b0;
						pproc_q   <= '0;
						resched_q <= 1'b0;
						rem_q     <= '0;
						bit_q     <= 5'(DrawW - 1);
					end
				end
				S_SLICE: begin
					if (op_q == OP_ENQ) begin
						if (queued_q[pid_q]) begin
							status_q <= ST_DUP;
						end else if (len_q >= CntW'(MaxProcs)) begin
							status_q <= ST_FULL;
						end
					end
				end
				S_ENQ: begin
					if (op_q == OP_ENQ) begin
						len_q           <= len_q + CntW'(1);
						sum_q           <= sum_q + SumW'(new_tkt);
						queued_q[pid_q] <= 1'b1;
					end else begin
						resched_q <= (s_rdata <= SliceW'(1));
					end
				end
				S_DEQ_RD: begin
					if (!queued_q[pid_q]) begin
						status_q <= ST_ABSENT;
					end
				end
				S_DEQ_CMP: begin
					if (rd_id == pid_q) begin
						sum_q           <= sum_q - SumW'(rd_tkt);
						len_q           <= len_q - CntW'(1);
						queued_q[pid_q] <= 1'b0;
					end else begin
						pos_q <= pos_q + PosW'(1);
						if (last_pos) begin
							queued_q[pid_q] <= 1'b0;
						end
					end
				end
				S_SHIFT_WR: pos_q <= pos_q + PosW'(1);
				S_MOD: begin
					if (len_q == '0) begin
						status_q <= ST_EMPTY;
					end else begin
						if (sum_q != '0) begin
							if (rem_sh >= {1'b0, sum_q}) begin
								rem_q <= SumW'(rem_sh - {1'b0, sum_q});
							end else begin
								rem_q <= SumW'(rem_sh);
							end
						end
						bit_q <= bit_q - 5'(1);
					end
				end
				S_WALK_CMP: begin
					if (pos_q == '0) begin
						first_id_q <= rd_id;
					end
					pvalid_q <= 1'b1;
					if (sum_q == '0) begin
						pproc_q <= (pos_q == '0) ? rd_id : first_id_q;
					end else if (SumW'(rd_tkt) > rem_q) begin
						pproc_q <= rd_id;
					end else begin
						pproc_q <= (pos_q == '0) ? rd_id : first_id_q;
					end
					rem_q <= rem_q - SumW'(rd_tkt);
					pos_q <= pos_q + PosW'(1);
				end
				S_OUT: out_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	// A result is never overwritten while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result lost while stalled");

	// No item is taken while a result is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken with result pending");

	// Queue length never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CntW'(MaxProcs))
		else $error("queue length overflow");
endmodule
